/* design/pmaqi_pkg.sv */
`timescale 1ns / 1ps
package pmaqi_pkg;

  localparam int FrameBytesDefault = 32;
  localparam logic [7:0] StartOneReset = 8'h42;
  localparam logic [7:0] StartTwoReset = 8'h4D;

  localparam int PmHiPos = 6;
  localparam int PmLoPos = 7;

  localparam int QueueDepth = 2;
  localparam int QPtrW = $clog2(QueueDepth);
  localparam int QCntW = $clog2(QueueDepth + 1);

  localparam int NumW = 18;
  localparam int MulW = 22;
  localparam int RecipShift = 28;
  localparam int QuoW = 7;
  localparam int AqiW = 9;
  localparam int SegW = 3;
  localparam logic [SegW-1:0] SegSat = 3'd7;
  localparam logic [SegW-1:0] SegWideFirst = 3'd3;

  localparam logic [12:0] SegHi [7] = '{13'd120, 13'd354, 13'd554, 13'd1504,
                                         13'd2504, 13'd3504, 13'd5004};
  localparam logic [12:0] SegLo [8] = '{13'd0, 13'd120, 13'd354, 13'd554,
                                         13'd1504, 13'd2504, 13'd3504, 13'd0};
  // ceil(2^28 / span) per segment, exact for every numerator up to 150000
  localparam logic [MulW-1:0] SegMul [8] = '{22'd2236963, 22'd1147161, 22'd1342178,
                                              22'd282564, 22'd268436, 22'd268436,
                                              22'd178957, 22'd0};
  localparam logic [AqiW-1:0] SegBase [8] = '{9'd0, 9'd50, 9'd100, 9'd150,
                                               9'd200, 9'd300, 9'd400, 9'd500};

  typedef struct packed {
    logic        ok;
    logic [15:0] pm_scaled;
  } job_t;

  function automatic logic [SegW-1:0] seg_of(input logic [15:0] pm);
    logic [SegW-1:0] seg;
    seg = SegSat;
    for (int i = 6; i >= 0; i--) begin
      if (pm <= 16'(SegHi[i])) seg = SegW'(i);
    end
    return seg;
  endfunction

endpackage

/* design/pmaqi_front.sv */
`timescale 1ns / 1ps
module pmaqi_front #(
  parameter int FRAME_BYTES = pmaqi_pkg::FrameBytesDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [7:0]        in_byte_i,
  output logic              in_ready_o,
  input  logic [7:0]        start_one_i,
  input  logic [7:0]        start_two_i,
  input  logic              full_i,
  output logic              push_o,
  output pmaqi_pkg::job_t   job_o
);
  import pmaqi_pkg::*;

  localparam int PosW = $clog2(FRAME_BYTES);
  localparam logic [PosW-1:0] PosZero = '0;
  localparam logic [PosW-1:0] PosOne = PosW'(1);
  localparam logic [PosW-1:0] PosHi = PosW'(PmHiPos);
  localparam logic [PosW-1:0] PosLo = PosW'(PmLoPos);
  localparam logic [PosW-1:0] PosCkHi = PosW'(FRAME_BYTES - 2);
  localparam logic [PosW-1:0] PosLast = PosW'(FRAME_BYTES - 1);

  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0] sum_q, sum_d;
  logic [15:0] pm_q, pm_d;
  logic [7:0] ck_hi_q, ck_hi_d;
  logic fire;

  assign in_ready_o = !full_i;
  assign fire = in_valid_i && in_ready_o;

  always_comb begin
    pos_d = pos_q;
    sum_d = sum_q;
    pm_d = pm_q;
    ck_hi_d = ck_hi_q;
    push_o = 1'b0;
    job_o.ok = ({ck_hi_q, in_byte_i} == sum_q);
    job_o.pm_scaled = (pm_q << 3) + (pm_q << 1);
    if (fire) begin
      if (pos_q == PosZero) begin
        if (in_byte_i == start_one_i) begin
          sum_d = 16'(in_byte_i);
          pos_d = PosOne;
        end
      end else if (pos_q == PosOne && in_byte_i != start_two_i) begin
        pos_d = PosZero;
      end else if (pos_q < PosCkHi) begin
        sum_d = sum_q + 16'(in_byte_i);
        if (pos_q == PosHi) pm_d[15:8] = in_byte_i;
        else if (pos_q == PosLo) pm_d[7:0] = in_byte_i;
        pos_d = pos_q + PosOne;
      end else if (pos_q == PosCkHi) begin
        ck_hi_d = in_byte_i;
        pos_d = pos_q + PosOne;
      end else begin
        push_o = 1'b1;
        pos_d = PosZero;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      sum_q <= '0;
      pm_q <= '0;
      ck_hi_q <= '0;
    end else begin
      pos_q <= pos_d;
      sum_q <= sum_d;
      pm_q <= pm_d;
      ck_hi_q <= ck_hi_d;
    end
  end

  a_push_at_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (pos_q == PosLast && !full_i))
    else $error("push away from last frame byte");

endmodule

/* design/pmaqi_queue.sv */
`timescale 1ns / 1ps
module pmaqi_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pmaqi_pkg::job_t   job_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output pmaqi_pkg::job_t   job_o
);
  import pmaqi_pkg::*;

  job_t job_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  assign full_o = (cnt_q == QCntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign job_o = job_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) job_q[wr_ptr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_ptr_q <= (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (pop_i) rd_ptr_q <= (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue underflow");

endmodule

/* design/pmaqi_back.sv */
`timescale 1ns / 1ps
module pmaqi_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  pmaqi_pkg::job_t   job_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              out_ok_o,
  output logic [15:0]       out_pm_o,
  output logic [8:0]        out_aqi_o
);
  import pmaqi_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv = 2'd1;
  localparam logic [1:0] StOut = 2'd2;

  logic [1:0] state_q, state_d;
  logic [NumW-1:0] num_q, num_d;
  logic [MulW-1:0] mul_q, mul_d;
  logic [AqiW-1:0] base_q, base_d;
  logic [QuoW-1:0] quo_q, quo_d;
  logic ok_q, ok_d;
  logic [15:0] pm_q, pm_d;
  logic [AqiW-1:0] stored_q, stored_d;
  logic out_valid_q, out_valid_d;
  logic out_ok_q, out_ok_d;
  logic [15:0] out_pm_q, out_pm_d;
  logic [AqiW-1:0] out_aqi_q, out_aqi_d;

  logic [SegW-1:0] seg;
  logic [15:0] diff_full;
  logic [10:0] diff;
  logic [NumW-1:0] num;
  logic [NumW+MulW-1:0] prod;
  logic [AqiW-1:0] aqi_new;
  logic out_free;

  assign seg = seg_of(job_i.pm_scaled);
  assign diff_full = job_i.pm_scaled - 16'(SegLo[seg]);
  assign diff = diff_full[10:0];
  assign prod = num_q * mul_q;
  assign aqi_new = base_q + AqiW'(quo_q);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    if (seg == SegSat) num = '0;
    else if (seg >= SegWideFirst)
      num = (NumW'(diff) << 6) + (NumW'(diff) << 5) + (NumW'(diff) << 2);
    else
      num = (NumW'(diff) << 5) + (NumW'(diff) << 4) + (NumW'(diff) << 1);
  end

  always_comb begin
    state_d = state_q;
    num_d = num_q;
    mul_d = mul_q;
    base_d = base_q;
    quo_d = quo_q;
    ok_d = ok_q;
    pm_d = pm_q;
    stored_d = stored_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_ok_d = out_ok_q;
    out_pm_d = out_pm_q;
    out_aqi_d = out_aqi_q;
    pop_o = 1'b0;
    case (state_q)
      StIdle: begin
        if (job_valid_i) begin
          pop_o = 1'b1;
          num_d = num;
          mul_d = SegMul[seg];
          base_d = SegBase[seg];
          ok_d = job_i.ok;
          pm_d = job_i.pm_scaled;
          state_d = StDiv;
        end
      end
      StDiv: begin
        quo_d = prod[RecipShift +: QuoW];
        state_d = StOut;
      end
      StOut: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_ok_d = ok_q;
          out_pm_d = pm_q;
          out_aqi_d = ok_q ? aqi_new : stored_q;
          if (ok_q) stored_d = aqi_new;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      stored_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stored_q <= stored_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    mul_q <= mul_d;
    base_q <= base_d;
    quo_q <= quo_d;
    ok_q <= ok_d;
    pm_q <= pm_d;
    out_ok_q <= out_ok_d;
    out_pm_q <= out_pm_d;
    out_aqi_q <= out_aqi_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_ok_o = out_ok_q;
  assign out_pm_o = out_pm_q;
  assign out_aqi_o = out_aqi_q;

  a_quo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut) |-> (quo_q <= 7'd100))
    else $error("segment quotient out of range");

  a_aqi_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_aqi_q <= 9'd500))
    else $error("index above limit");

endmodule

/* design/pm_frame_receiver_aqi_core.sv */
`timescale 1ns / 1ps
// path: after the last byte of a frame is transferred, the job passes through the queue
// and the back end's idle, divide and output states before m_axis_tvalid rises
// throughput: one byte per cycle while the job queue is not full; the back end takes
// one frame at a time through segment select, reciprocal multiply and output, so the
// 2-entry job queue fills only under output backpressure
// reset: asynchronous active low; clears position, sum, captured pm, checksum byte,
// stored index and queue; start bytes return to 0x42 and 0x4D
module pm_frame_receiver_aqi_core #(
  parameter int FRAME_BYTES = pmaqi_pkg::FrameBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // checksum_ok, pm_scaled, air_index, zero fill
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pmaqi_pkg::*;

  localparam logic RegStartOne = 1'b0;
  localparam logic RegStartTwo = 1'b1;

  logic [7:0] start_one_q, start_two_q;
  logic cfg_wr;
  logic push, full, pop, job_valid;
  job_t job_in, job_out;
  logic out_ok;
  logic [15:0] out_pm;
  logic [8:0] out_aqi;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_one_q <= StartOneReset;
      start_two_q <= StartTwoReset;
    end else if (cfg_wr) begin
      case (paddr[2])
        RegStartOne: start_one_q <= pwdata[7:0];
        RegStartTwo: start_two_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegStartOne: prdata = {24'b0, start_one_q};
      RegStartTwo: prdata = {24'b0, start_two_q};
      default: prdata = '0;
    endcase
  end

  pmaqi_front #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_byte_i  (s_axis_tdata),
    .in_ready_o (s_axis_tready),
    .start_one_i(start_one_q),
    .start_two_i(start_two_q),
    .full_i     (full),
    .push_o     (push),
    .job_o      (job_in)
  );

  pmaqi_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_in),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(job_valid),
    .job_o  (job_out)
  );

  pmaqi_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(job_valid),
    .job_i      (job_out),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_ok_o   (out_ok),
    .out_pm_o   (out_pm),
    .out_aqi_o  (out_aqi)
  );

  assign m_axis_tdata = {6'b0, out_aqi, out_pm, out_ok};

endmodule

/* tb/sv/pm_frame_receiver_aqi_core_tb.sv */
`timescale 1ns / 1ps
module pm_frame_receiver_aqi_core_tb;
  import pmaqi_pkg::*;

  localparam int FrameLen = FrameBytesDefault;
  localparam logic [2:0] AddrStartOne = 3'd0;
  localparam logic [2:0] AddrStartTwo = 3'd4;
  localparam int SettleCycles = 20;
  localparam int LongHoldCycles = 400;
  localparam int DrainLimit = 20000;
  localparam int TimeoutNs = 5_000_000;
  localparam logic [15:0] CornerPm [10] = '{16'd0, 16'd12, 16'd35, 16'd36, 16'd151,
                                             16'd350, 16'd501, 16'd6554, 16'hFFFF,
                                             16'd100};

  typedef struct packed {
    logic       ok;
    logic [15:0] pm_scaled;
    logic [8:0]  air_index;
  } frame_result_t;

  class aqi_frame_scoreboard;
    logic [7:0]    start_one = StartOneReset;
    logic [7:0]    start_two = StartTwoReset;
    int unsigned   position = 0;
    logic [15:0]   byte_sum = '0;
    logic [15:0]   pm_word = '0;
    logic [7:0]    sum_high = '0;
    logic [8:0]    held_index = '0;
    frame_result_t expected_frames[$];
    int            errors = 0;

    task report(input string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function int pending();
      return expected_frames.size();
    endfunction

    function logic [8:0] air_index_of(input logic [15:0] pm);
      int p;
      p = pm;
      if (p <= 120) return 9'(p * 50 / 120);
      if (p <= 354) return 9'(50 + (p - 120) * 50 / 234);
      if (p <= 554) return 9'(100 + (p - 354) * 50 / 200);
      if (p <= 1504) return 9'(150 + (p - 554) * 100 / 950);
      if (p <= 2504) return 9'(200 + (p - 1504) * 100 / 1000);
      if (p <= 3504) return 9'(300 + (p - 2504) * 100 / 1000);
      if (p <= 5004) return 9'(400 + (p - 3504) * 100 / 1500);
      return 9'd500;
    endfunction

    function void note_byte(input logic [7:0] b);
      frame_result_t r;
      if (position == 0) begin
        if (b == start_one) begin
          byte_sum = 16'(b);
          position = 1;
        end
      end else if (position == 1 && b != start_two) begin
        position = 0;
      end else if (position < FrameLen - 2) begin
        byte_sum = byte_sum + 16'(b);
        if (position == PmHiPos) pm_word[15:8] = b;
        else if (position == PmLoPos) pm_word[7:0] = b;
        position++;
      end else if (position == FrameLen - 2) begin
        sum_high = b;
        position++;
      end else begin
        r.ok = ({sum_high, b} == byte_sum);
        r.pm_scaled = 16'(pm_word * 10);
        if (r.ok) held_index = air_index_of(r.pm_scaled);
        r.air_index = held_index;
        expected_frames.push_back(r);
        position = 0;
      end
    endfunction

    task check_frame(input logic [31:0] data);
      frame_result_t e;
      if (expected_frames.size() == 0) begin
        report($sformatf("result with no frame pending, data %h", data));
        return;
      end
      e = expected_frames.pop_front();
      if (data[0] !== e.ok)
        report($sformatf("checksum_ok %b, expected %b", data[0], e.ok));
      if (data[16:1] !== e.pm_scaled)
        report($sformatf("pm_scaled %0d, expected %0d", data[16:1], e.pm_scaled));
      if (data[25:17] !== e.air_index)
        report($sformatf("air_index %0d, expected %0d", data[25:17], e.air_index));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  aqi_frame_scoreboard aqi_sb;
  int bytes_sent = 0;
  int hold_cycles = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;

  pm_frame_receiver_aqi_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(TimeoutNs);
    $display("FAILURE");
    $finish;
  end

  task automatic apb_xfer(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_starts(input logic [7:0] one, input logic [7:0] two);
    logic [31:0] rd;
    apb_xfer(1'b1, AddrStartOne, {24'd0, one}, rd);
    apb_xfer(1'b1, AddrStartTwo, {24'd0, two}, rd);
    aqi_sb.start_one = one;
    aqi_sb.start_two = two;
    apb_xfer(1'b0, AddrStartOne, '0, rd);
    if (rd[7:0] !== one) aqi_sb.report($sformatf("start_byte_one reads %h", rd));
    apb_xfer(1'b0, AddrStartTwo, '0, rd);
    if (rd[7:0] !== two) aqi_sb.report($sformatf("start_byte_two reads %h", rd));
  endtask

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_idle ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    aqi_sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [15:0] pm, input bit bad_sum);
    logic [7:0]  fr [FrameLen];
    logic [15:0] sum;
    fr[0] = aqi_sb.start_one;
    fr[1] = aqi_sb.start_two;
    for (int i = 2; i < FrameLen - 2; i++) fr[i] = 8'($urandom);
    fr[PmHiPos] = pm[15:8];
    fr[PmLoPos] = pm[7:0];
    sum = '0;
    for (int i = 0; i < FrameLen - 2; i++) sum += 16'(fr[i]);
    if (bad_sum) sum ^= 16'($urandom_range(1, 65535));
    fr[FrameLen - 2] = sum[15:8];
    fr[FrameLen - 1] = sum[7:0];
    foreach (fr[i]) send_byte(fr[i]);
  endtask

  function automatic logic [15:0] random_pm();
    if ($urandom_range(0, 1)) return 16'($urandom_range(0, 520));
    return 16'($urandom);
  endfunction

  task automatic run_random(input int count);
    int stop_at;
    int pick;
    int k;
    logic [7:0] b;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        send_frame(random_pm(), $urandom_range(0, 99) < 15);
      end else if (pick < 82) begin
        k = $urandom_range(1, 8);
        repeat (k) send_byte(8'($urandom));
      end else if (pick < 94) begin
        b = 8'($urandom);
        if (b == aqi_sb.start_two) b = ~b;
        send_byte(aqi_sb.start_one);
        send_byte(b);
      end else begin
        // truncated frame, the next one gets absorbed into it
        k = $urandom_range(0, 20);
        send_byte(aqi_sb.start_one);
        send_byte(aqi_sb.start_two);
        repeat (k) send_byte(8'($urandom));
      end
    end
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    while (aqi_sb.pending() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    if (aqi_sb.pending() != 0)
      aqi_sb.report($sformatf("%0d frame results never arrived", aqi_sb.pending()));
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin : result_sink
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = hold_cycles + (rx_idle ? $urandom_range(0, 17) : 0);
      hold_cycles = 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      aqi_sb.check_frame(m_axis_tdata);
    end
  end

  initial begin : stimulus
    aqi_sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // hunting: wrong first bytes, wrong second byte that is not retried
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(StartOneReset);
    send_byte(StartOneReset);
    foreach (CornerPm[i]) send_frame(CornerPm[i], i == 9);
    send_frame(16'd250, 1'b0);
    send_frame(16'd0, 1'b1);

    run_random(200);
    drain();

    set_starts(8'h00, 8'hFF);
    tx_idle = 1'b0;
    run_random(180);
    drain();

    // receiver holds off while the sender keeps streaming
    set_starts(8'hFF, 8'h00);
    rx_idle = 1'b0;
    hold_cycles = LongHoldCycles;
    repeat (16) send_frame(random_pm(), 1'b0);
    drain();

    set_starts(8'($urandom), 8'($urandom));
    tx_idle = 1'b1;
    run_random(180);
    drain();

    set_starts(8'h5A, 8'h5A);
    rx_idle = 1'b1;
    run_random(160);
    drain();

    set_starts(StartOneReset, StartTwoReset);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    run_random(160);
    drain();

    if (aqi_sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
